### rtl/tkst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkst_pkg
// Shared types and constants of the top-k named score table.
// ----------------------------------------------------------------------------
package tkst_pkg;
	localparam int TableEntries = 24;
	localparam int RankW = 5;
	localparam int NameBytes = 23;
	localparam int ScoreW = 31;

	localparam logic [2:0] StBadName  = 3'd0;
	localparam logic [2:0] StUpdated  = 3'd1;
	localparam logic [2:0] StInserted = 3'd2;
	localparam logic [2:0] StNotQual  = 3'd3;
	localparam logic [2:0] StRead     = 3'd4;

	localparam logic CmdInsert = 1'b0;
	localparam logic CmdRead   = 1'b1;

	typedef struct packed {
		logic [63:0]       n0;
		logic [63:0]       n1;
		logic [63:0]       n2;
		logic [ScoreW-1:0] pts;
	} entry_t;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic   ins;   // evict bottom, take new entry at its sorted place
		logic   upd;   // raise score of the matching entry and re-place it
		entry_t ent;
	} cell_ctl_t;

	// true when a ranks strictly before b
	function automatic logic ranks_before(entry_t a, entry_t b);
		if (a.pts != b.pts) return a.pts > b.pts;
		if (a.n0 != b.n0) return a.n0 < b.n0;
		if (a.n1 != b.n1) return a.n1 < b.n1;
		return a.n2 < b.n2;
	endfunction
endpackage
`default_nettype wire

### rtl/tkst_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkst_cell
// One slot of the sorted table; shifts toward the bottom to open a gap.
// ----------------------------------------------------------------------------
module tkst_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tkst_pkg::cell_ctl_t ctl,
	input  wire tkst_pkg::entry_t   up_ent,     // neighbor above
	input  wire logic               up_after,   // new entry ranks after neighbor above
	input  wire logic               up_match,   // match lies above or at neighbor above
	input  wire logic               is_top,
	input  wire logic               is_bottom,
	output tkst_pkg::entry_t        ent,
	output logic                    after,
	output logic                    match_here,
	output logic                    match_at_or_above
);
	tkst_pkg::entry_t ent_q;
	tkst_pkg::entry_t nxt;
	logic up_a, ent_match;

	assign ent = ent_q;
	assign ent_match = (ent_q.n0 == ctl.ent.n0) && (ent_q.n1 == ctl.ent.n1) &&
		(ent_q.n2 == ctl.ent.n2);
	assign match_here = ent_match;
	assign match_at_or_above = ent_match | (up_match & ~is_top);
	// for update, the entry compared against carries the raised score
	assign after = !tkst_pkg::ranks_before(ctl.ent, ent_q);
	// nothing lies above the top cell, so the new entry always ranks after it
	assign up_a = is_top ? 1'b1 : up_after;

	always_comb begin
		nxt = ent_q;
		if (ctl.ins) begin
			// cells after the insertion point move down by one; the bottom
			// cell is evicted and takes the new entry when it lands last
			if (!after || is_bottom) nxt = up_a ? ctl.ent : up_ent;
		end else if (ctl.upd) begin
			// match only moves up (score never drops): cells from the new place
			// down to the match move down by one
			if (match_at_or_above && !(up_match & ~is_top) ) begin
				if (!up_a && !is_top) nxt = up_ent;
				else nxt = ctl.ent;
			end else if (!after && !match_at_or_above) begin
				nxt = up_a ? ctl.ent : up_ent;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			ent_q <= nxt;
		end
	end
endmodule
`default_nettype wire

### rtl/top_k_named_score_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// top_k_named_score_table
// Sorted top-k table of named scores built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Requests enter on s_axis (tdata holds name words, score and rank; tuser is
// the command: 0 insert/update, 1 read). One result per request leaves on
// m_axis (tdata holds the three name words, score and the empty flag; tuser
// is the status code).
// A request is latched and normalized when it is accepted; in the EXEC state
// the chain is evaluated, and as that state ends every cell updates together
// and the result is written to the output register.
// A new request is taken only once the output register is free, so the
// table takes no new request before the last result has been accepted.
// While the receiver stalls the result holds and no further request is
// accepted. Reset empties every slot at once.
// An update keeps the higher score; since a score never falls, the matching
// entry only moves toward the top, and the cells between shift down by one.
// ----------------------------------------------------------------------------
module top_k_named_score_table (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// name_word_0, name_word_1, name_word_2, score, rank_index, 4'b0
	input  wire logic [231:0] s_axis_tdata,
	input  wire logic         s_axis_tuser,   // command
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// entry_name_0, entry_name_1, entry_name_2, entry_score, entry_is_empty
	output logic [223:0]      m_axis_tdata,
	output logic [2:0]        m_axis_tuser    // status
);
	localparam int N = tkst_pkg::TableEntries;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;
	state_t state_q;

	logic                          cmd_q;
	tkst_pkg::entry_t              req_q;
	logic                          printable_q;
	logic [tkst_pkg::RankW-1:0]    rank_q;
	logic                          out_valid_q;
	logic [223:0]                  out_data_q;
	logic [2:0]                    out_user_q;

	tkst_pkg::entry_t norm;
	logic             norm_pr;

	// normalize: keep bytes up to first zero, replace nonprintables
	always_comb begin
		logic [191:0] src;
		logic [191:0] dst;
		logic stop;
		logic [7:0] c;
		// byte 0 of the name is the top byte of name_word_0
		src = {s_axis_tdata[63:0], s_axis_tdata[127:64], s_axis_tdata[191:128]};
		dst = '0;
		stop = 1'b0;
		norm_pr = 1'b0;
		for (int k = 0; k < tkst_pkg::NameBytes; k++) begin
			c = src[191-8*k -: 8];
			if (c == 8'd0) stop = 1'b1;
			if (!stop) begin
				if (c >= 8'd32 && c <= 8'd126) norm_pr = 1'b1;
				else c = 8'h3F;
				dst[191-8*k -: 8] = c;
			end
		end
		norm.n0 = dst[191:128];
		norm.n1 = dst[127:64];
		norm.n2 = dst[63:0];
		norm.pts = s_axis_tdata[222:192];
	end

	assign s_axis_tready = (state_q == S_IDLE) && !out_valid_q;

	tkst_pkg::entry_t ents [N];
	logic afters [N];
	logic mh [N];
	logic mab [N];
	tkst_pkg::cell_ctl_t ctl;
	logic any_match, any_empty, do_ins, do_upd;
	tkst_pkg::entry_t upd_ent;

	always_comb begin
		any_match = 1'b0;
		any_empty = 1'b0;
		upd_ent = req_q;
		for (int i = 0; i < N; i++) begin
			if (mh[i]) begin
				any_match = 1'b1;
				if (ents[i].pts > req_q.pts) upd_ent.pts = ents[i].pts;
			end
			if (ents[i] == '0) any_empty = 1'b1;
		end
	end

	assign do_upd = (state_q == S_EXEC) && cmd_q == tkst_pkg::CmdInsert && printable_q &&
		any_match;
	assign do_ins = (state_q == S_EXEC) && cmd_q == tkst_pkg::CmdInsert && printable_q &&
		!any_match && (any_empty || req_q.pts > ents[N-1].pts);
	assign ctl.ins = do_ins;
	assign ctl.upd = do_upd;
	// match test uses the request name; placement uses the raised score
	assign ctl.ent.n0 = req_q.n0;
	assign ctl.ent.n1 = req_q.n1;
	assign ctl.ent.n2 = req_q.n2;
	assign ctl.ent.pts = do_upd ? upd_ent.pts : req_q.pts;

	for (genvar i = 0; i < N; i++) begin : g_cell
		tkst_cell u_cell (
			.clk               (clk),
			.arst_n            (arst_n),
			.ctl               (ctl),
			.up_ent            (ents[(i == 0) ? 0 : i-1]),
			.up_after          (afters[(i == 0) ? 0 : i-1]),
			.up_match          ((i == 0) ? 1'b0 : mab[(i == 0) ? 0 : i-1]),
			.is_top            (i == 0),
			.is_bottom         (i == N-1),
			.ent               (ents[i]),
			.after             (afters[i]),
			.match_here        (mh[i]),
			.match_at_or_above (mab[i])
		);
	end

	logic [2:0] status;
	tkst_pkg::entry_t rd_ent;
	logic rd_in;
	always_comb begin
		rd_in = rank_q < tkst_pkg::RankW'(N);
		rd_ent = '0;
		for (int i = 0; i < N; i++)
			if (rank_q == tkst_pkg::RankW'(i)) rd_ent = ents[i];
		if (cmd_q == tkst_pkg::CmdRead) status = tkst_pkg::StRead;
		else if (!printable_q) status = tkst_pkg::StBadName;
		else if (any_match) status = tkst_pkg::StUpdated;
		else if (do_ins) status = tkst_pkg::StInserted;
		else status = tkst_pkg::StNotQual;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					out_valid_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_q <= s_axis_tuser;
			req_q <= norm;
			printable_q <= norm_pr;
			rank_q <= s_axis_tdata[227:223];
		end
		if (state_q == S_EXEC) begin
			out_user_q <= status;
			if (cmd_q == tkst_pkg::CmdRead && rd_in)
				out_data_q <= {(rd_ent == '0), rd_ent.pts, rd_ent.n2, rd_ent.n1, rd_ent.n0};
			else if (cmd_q == tkst_pkg::CmdRead)
				out_data_q <= {1'b1, 223'd0};
			else
				out_data_q <= '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {out_data_q[223], out_data_q[222:0]};
	assign m_axis_tuser = out_user_q;

	a_one_hot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> !s_axis_tready) else $error("accept while busy");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(do_ins && do_upd))
		else $error("insert and update together");
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |=> m_axis_tvalid) else $error("result lost");
endmodule
`default_nettype wire

### tb/top_k_named_score_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_named_score_table_tb
// Self-checking bench for the sorted top-k named score table.
// ----------------------------------------------------------------------------
// A directed table covers the reset state, out-of-range ranks, bad names,
// name cleanup, update and insert. Random requests follow; most insert names
// come from a small pool so that updates, ties, evictions and dropped
// requests are common. Every result is checked against a local table
// model. Both stream sides idle at random, and once the receiver holds
// off long enough to stall the request side.
// ----------------------------------------------------------------------------
module top_k_named_score_table_tb;

	typedef struct {
		logic [2:0]                  status;
		logic [63:0]                 n0;
		logic [63:0]                 n1;
		logic [63:0]                 n2;
		logic [tkst_pkg::ScoreW-1:0] pts;
		logic                        empty;
	} outcome_t;

	typedef struct {
		logic                        cmd;
		logic [191:0]                raw;   // name bytes 0..23, byte 0 at the top
		logic [tkst_pkg::ScoreW-1:0] pts;
		logic [tkst_pkg::RankW-1:0]  rank;
		bit                          fixed; // result known by inspection
		logic [2:0]                  fx_status;
		logic                        fx_empty;
	} request_t;

	localparam int PoolSize = 40;
	localparam int RandomItems = 1000;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [231:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [223:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;

	tkst_pkg::entry_t score_table[tkst_pkg::TableEntries];
	outcome_t pending_results[$];
	logic [191:0] name_pool[PoolSize];
	bit failed = 1'b0;
	bit cur_fixed = 1'b0;
	logic [2:0] cur_fx_status = '0;
	logic cur_fx_empty = 1'b0;
	bit stall_request = 1'b0;
	bit stimulus_done = 1'b0;

	top_k_named_score_table u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit sorts_ahead(tkst_pkg::entry_t a, tkst_pkg::entry_t b);
		if (a.pts != b.pts) return a.pts > b.pts;
		return {a.n0, a.n1, a.n2} < {b.n0, b.n1, b.n2};
	endfunction

	function automatic void resort_table();
		tkst_pkg::entry_t t;
		int j;
		for (int i = 1; i < tkst_pkg::TableEntries; i++) begin
			j = i;
			while (j > 0 && sorts_ahead(score_table[j], score_table[j-1])) begin
				t = score_table[j];
				score_table[j] = score_table[j-1];
				score_table[j-1] = t;
				j--;
			end
		end
	endfunction

	// Apply one request to the model table and return its result.
	function automatic outcome_t apply_request(logic cmd, logic [191:0] raw,
			logic [tkst_pkg::ScoreW-1:0] pts, logic [tkst_pkg::RankW-1:0] rank);
		outcome_t o;
		logic [191:0] clean;
		logic [7:0] c;
		bit printable;
		bit any_empty;
		tkst_pkg::entry_t e;
		o = '{tkst_pkg::StRead, '0, '0, '0, '0, 1'b0};
		clean = '0;
		printable = 1'b0;
		any_empty = 1'b0;
		if (cmd == tkst_pkg::CmdRead) begin
			if (rank >= tkst_pkg::TableEntries) begin
				o.empty = 1'b1;
			end else begin
				e = score_table[rank];
				o.n0 = e.n0;
				o.n1 = e.n1;
				o.n2 = e.n2;
				o.pts = e.pts;
				o.empty = (e == '0);
			end
			return o;
		end
		for (int k = 0; k < tkst_pkg::NameBytes; k++) begin
			c = raw[191-8*k -: 8];
			if (c == 8'd0) break;
			if (c >= 8'd32 && c <= 8'd126) printable = 1'b1;
			else c = "?";
			clean[191-8*k -: 8] = c;
		end
		if (!printable) begin
			o.status = tkst_pkg::StBadName;
			return o;
		end
		for (int i = 0; i < tkst_pkg::TableEntries; i++) begin
			if ({score_table[i].n0, score_table[i].n1, score_table[i].n2} == clean) begin
				if (pts > score_table[i].pts) score_table[i].pts = pts;
				resort_table();
				o.status = tkst_pkg::StUpdated;
				return o;
			end
		end
		for (int i = 0; i < tkst_pkg::TableEntries; i++)
			if (score_table[i] == '0) any_empty = 1'b1;
		if (!any_empty && pts <= score_table[tkst_pkg::TableEntries-1].pts) begin
			o.status = tkst_pkg::StNotQual;
			return o;
		end
		score_table[tkst_pkg::TableEntries-1] =
			'{clean[191:128], clean[127:64], clean[63:0], pts};
		resort_table();
		o.status = tkst_pkg::StInserted;
		return o;
	endfunction

	function automatic logic [191:0] make_name(int len, bit noisy);
		logic [191:0] r;
		r = '0;
		for (int k = 0; k < len && k < 24; k++)
			r[191-8*k -: 8] = (noisy && $urandom_range(0, 7) == 0) ?
				8'($urandom_range(1, 255)) : 8'($urandom_range(32, 126));
		// garbage after the terminator must be ignored
		if (noisy && len < 23) begin
			r[191-8*len -: 8] = 8'd0;
			for (int k = len + 1; k < 24; k++) r[191-8*k -: 8] = 8'($urandom);
		end
		return r;
	endfunction

	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_request(request_t q);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= q.cmd;
		s_axis_tdata <= {4'b0, q.rank, q.pts, q.raw[63:0], q.raw[127:64], q.raw[191:128]};
		cur_fixed <= q.fixed;
		cur_fx_status <= q.fx_status;
		cur_fx_empty <= q.fx_empty;
		do @(posedge clk); while (!s_axis_tready);
		gap = stall_request ? 0 : gap_cycles();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Prediction on request acceptance, checking on result acceptance.
	always @(posedge clk) begin
		outcome_t o;
		outcome_t want;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			o = apply_request(s_axis_tuser,
				{s_axis_tdata[63:0], s_axis_tdata[127:64], s_axis_tdata[191:128]},
				s_axis_tdata[222:192], s_axis_tdata[227:223]);
			if (cur_fixed) o = '{cur_fx_status, '0, '0, '0, '0, cur_fx_empty};
			pending_results.push_back(o);
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result status %0d", $time, m_axis_tuser);
				failed = 1'b1;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tuser !== want.status || m_axis_tdata[63:0] !== want.n0 ||
						m_axis_tdata[127:64] !== want.n1 ||
						m_axis_tdata[191:128] !== want.n2 ||
						m_axis_tdata[222:192] !== want.pts ||
						m_axis_tdata[223] !== want.empty) begin
					$display("%0t: mismatch expected st=%0d %h %h %h pts=%0d empty=%b",
						$time, want.status, want.n0, want.n1, want.n2, want.pts,
						want.empty);
					$display("%0t:          actual st=%0d %h %h %h pts=%0d empty=%b",
						$time, m_axis_tuser, m_axis_tdata[63:0], m_axis_tdata[127:64],
						m_axis_tdata[191:128], m_axis_tdata[222:192], m_axis_tdata[223]);
					failed = 1'b1;
				end
			end
		end
	end

	// Receiver: ready stretches, short stalls, a few long ones, one long hold.
	initial begin
		int r;
		int n;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (stall_request && !held) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			r = $urandom_range(0, 99);
			if (r < 60) begin
				m_axis_tready <= 1'b1;
				n = $urandom_range(1, 20);
			end else begin
				m_axis_tready <= 1'b0;
				n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
			end
			repeat (n) @(posedge clk);
		end
	end

	initial begin
		request_t directed[$];
		request_t q;
		int r;
		arst_n = 1'b0;
		for (int i = 0; i < tkst_pkg::TableEntries; i++) score_table[i] = '0;
		for (int i = 0; i < PoolSize; i++) name_pool[i] = make_name($urandom_range(1, 23), 1'b0);
		directed = '{
			'{tkst_pkg::CmdRead, '0, '0, 5'd0, 1, tkst_pkg::StRead, 1'b1},
			'{tkst_pkg::CmdRead, '0, '0, 5'd23, 1, tkst_pkg::StRead, 1'b1},
			'{tkst_pkg::CmdRead, '1, '1, 5'd31, 1, tkst_pkg::StRead, 1'b1},
			'{tkst_pkg::CmdInsert, '0, 31'd5, '0, 1, tkst_pkg::StBadName, 1'b0},
			'{tkst_pkg::CmdInsert, {8'h01, 8'hff, 8'h7f, 8'h1f, 168'h0}, 31'd9, '0, 1,
				tkst_pkg::StBadName, 1'b0},
			'{tkst_pkg::CmdInsert, {8'h00, 184'h41424344}, 31'd9, '0, 1,
				tkst_pkg::StBadName, 1'b0},
			'{tkst_pkg::CmdInsert, {"A", 184'h0}, 31'h7fffffff, '0, 1,
				tkst_pkg::StInserted, 1'b0},
			'{tkst_pkg::CmdInsert, {"A", 184'h0}, 31'd3, '0, 1, tkst_pkg::StUpdated, 1'b0},
			'{tkst_pkg::CmdRead, '0, '0, 5'd0, 0, tkst_pkg::StRead, 1'b0},
			'{tkst_pkg::CmdInsert, {"A", 8'h05, 8'h80, "~", 8'h20, 152'h0}, 31'd100, '0,
				0, 0, 0},
			'{tkst_pkg::CmdInsert, {8'h7f, 8'hff, "z", 168'h0}, 31'd100, '0, 0, 0, 0},
			'{tkst_pkg::CmdInsert, {184'h0, 8'h0} | '1, 31'h7fffffff, '1, 0, 0, 0},
			'{tkst_pkg::CmdInsert, {"B", 184'h0}, 31'd0, '0, 1, tkst_pkg::StInserted, 1'b0},
			'{tkst_pkg::CmdInsert, {"Z", 184'h0}, 31'd100, '0, 0, 0, 0},
			'{tkst_pkg::CmdInsert, {"Z", 184'h0}, 31'd200, '0, 1, tkst_pkg::StUpdated, 1'b0},
			'{tkst_pkg::CmdRead, '0, '0, 5'd0, 0, 0, 0},
			'{tkst_pkg::CmdRead, '0, '0, 5'd1, 0, 0, 0},
			'{tkst_pkg::CmdRead, '0, '0, 5'd2, 0, 0, 0},
			'{tkst_pkg::CmdRead, '0, '0, 5'd5, 0, 0, 0},
			'{tkst_pkg::CmdRead, '0, '0, 5'd6, 0, 0, 0},
			'{tkst_pkg::CmdRead, '0, '0, 5'd24, 1, tkst_pkg::StRead, 1'b1}
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) send_request(directed[i]);
		for (int i = 0; i < RandomItems; i++) begin
			q = '{tkst_pkg::CmdInsert, '0, '0, '0, 0, tkst_pkg::StRead, 1'b0};
			q.rank = 5'($urandom_range(0, 31));
			r = $urandom_range(0, 99);
			if (r < 25) q.cmd = tkst_pkg::CmdRead;
			else if (r < 70) q.raw = name_pool[$urandom_range(0, PoolSize - 1)];
			else if (r < 82) q.raw = make_name($urandom_range(1, 24), 1'b1);
			else if (r < 92) q.raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			else if (r < 96) q.raw = make_name($urandom_range(0, 4), 1'b0) >> 8;
			else q.raw = {8'($urandom_range(1, 31)), 8'($urandom_range(127, 255)), 176'h0};
			r = $urandom_range(0, 99);
			if (r < 50) q.pts = 31'($urandom_range(0, 60));
			else if (r < 90) q.pts = 31'($urandom);
			else q.pts = (r < 95) ? 31'h7fffffff : 31'd0;
			if (i == 300) stall_request <= 1'b1;
			if (i == 340) stall_request <= 1'b0;
			send_request(q);
		end
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (!failed) begin
			$display("top_k_named_score_table verification clean");
		end else begin
			$display("top_k_named_score_table verification failed");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("top_k_named_score_table verification failed");
		$finish;
	end
endmodule

### files.f
rtl/tkst_pkg.sv
rtl/tkst_cell.sv
rtl/top_k_named_score_table.sv
tb/top_k_named_score_table_tb.sv
